[rtl/huffman_code_bit_packer_core_assert.svh]
// assertion macros for the huffman code bit packer core
// included by files that check their own logic; no other dependencies
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must never be true
`define HCBP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define HCBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define HCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HCBP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define HCBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define HCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/hcbp_pkg.sv]
// shared types and constants of the huffman code bit packer
// no dependencies
package hcbp_pkg;

  localparam int NUM_SYMBOLS_DEF  = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int BYTE_W    = 8;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int MODE_W    = 2;
  // symbol, code word and code length, padded to whole bytes
  localparam int IN_DATA_W = ((SYM_W + CODE_W + LEN_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

  // command queue between front and back, power of two deep
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // item kinds as they arrive on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  // work handed to the back end
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CODE_W-1:0]   code;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage

[rtl/hcbp_ram.sv]
// generic single write port ram with registered read
// no dependencies
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/hcbp_front.sv]
// front end: accepts items, writes the code table, looks up encode symbols
// depends on hcbp_pkg and hcbp_ram
module hcbp_front #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [hcbp_pkg::MODE_W-1:0]    in_tuser,
  input  logic [hcbp_pkg::QC_W-1:0]      q_level,
  output logic                           q_push,
  output hcbp_pkg::cmd_t                 q_cmd
);
  import hcbp_pkg::*;

  localparam int               IDXW    = $clog2(NUM_SYMBOLS);
  localparam int               RAMW    = CODE_W + LEN_W;
  localparam logic [SYM_W:0]   SYM_LIM = (SYM_W + 1)'(NUM_SYMBOLS);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_CODE_LEN);

  logic [SYM_W-1:0]   sym;
  logic [CODE_W-1:0]  word;
  logic [LEN_W-1:0]   len_in;
  logic [LEN_W-1:0]   sat_len;
  logic [CODE_W:0]    mask_full;
  mode_t              mode;
  logic [IDXW-1:0]    idx;
  logic               in_range;
  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [RAMW-1:0]    ram_rdata;

  logic [NUM_SYMBOLS-1:0] vld_r, vld_nxt;
  logic                   s1_vld_r, s1_vld_nxt;
  cmd_kind_t              s1_kind_r, s1_kind_nxt;
  logic                   s1_hit_r, s1_hit_nxt;

  // field unpacking
  assign sym      = in_tdata[SYM_W-1:0];
  assign word     = in_tdata[SYM_W +: CODE_W];
  assign len_in   = in_tdata[SYM_W + CODE_W +: LEN_W];
  assign mode     = mode_t'(in_tuser);
  assign idx      = sym[IDXW-1:0];
  assign in_range = ({1'b0, sym} < SYM_LIM);

  // leave a queue slot for the lookup still in flight
  assign in_tready = s1_vld_r ? (q_level < QC_W'(Q_DEPTH - 1)) : (q_level < QC_W'(Q_DEPTH));
  assign accept    = in_tvalid & in_tready;

  // saturate the length and drop code bits above it before storing
  assign sat_len   = (len_in > LEN_CAP) ? LEN_CAP : len_in;
  assign mask_full = ((CODE_W + 1)'(1) << sat_len) - (CODE_W + 1)'(1);

  // item classification
  always_comb begin
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    s1_vld_nxt  = 1'b0;
    s1_kind_nxt = CMD_ENCODE;
    case (mode)
      MODE_LOAD: begin
        ram_we = accept & in_range;
      end
      MODE_ENCODE: begin
        ram_re     = accept & in_range;
        s1_vld_nxt = accept & in_range;
      end
      MODE_FLUSH: begin
        s1_vld_nxt  = accept;
        s1_kind_nxt = CMD_FLUSH;
      end
      default: begin
        s1_vld_nxt = 1'b0;
      end
    endcase
  end

  // entry valid bits; an unwritten entry reads as zero length
  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[idx] = 1'b1;
    end
  end

  assign s1_hit_nxt = ram_re & vld_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      s1_vld_r  <= 1'b0;
      s1_kind_r <= CMD_ENCODE;
      s1_hit_r  <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s1_kind_r <= s1_kind_nxt;
      s1_hit_r  <= s1_hit_nxt;
    end
  end

  // code and length table
  hcbp_ram #(
    .WIDTH (RAMW),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({sat_len, word & mask_full[CODE_W-1:0]}),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // lookup result goes into the queue the cycle after the item
  always_comb begin
    q_push      = s1_vld_r;
    q_cmd.kind  = s1_kind_r;
    q_cmd.code  = s1_hit_r ? ram_rdata[CODE_W-1:0] : '0;
    q_cmd.len   = s1_hit_r ? ram_rdata[CODE_W +: LEN_W] : '0;
  end

endmodule

[rtl/hcbp_queue.sv]
// short command queue between front and back end
// depends on hcbp_pkg
module hcbp_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  hcbp_pkg::cmd_t            push_cmd,
  input  logic                      pop,
  output logic                      head_vld,
  output hcbp_pkg::cmd_t            head_cmd,
  output logic [hcbp_pkg::QC_W-1:0] level
);
  import hcbp_pkg::*;

  cmd_t              mem [Q_DEPTH];
  logic [QP_W-1:0]   wptr_r, wptr_nxt;
  logic [QP_W-1:0]   rptr_r, rptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + QP_W'(1);
    end
    if (pop) begin
      rptr_nxt = rptr_r + QP_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_cmd;
    end
  end

  assign head_vld = (cnt_r != '0);
  assign head_cmd = mem[rptr_r];
  assign level    = cnt_r;

endmodule

[rtl/hcbp_back.sv]
// back end: bit accumulator, byte emission and output register
// depends on hcbp_pkg
module hcbp_back #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  input  hcbp_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hcbp_pkg::BYTE_W-1:0] out_tdata,
  output logic                        out_tlast
);
  import hcbp_pkg::*;

  // up to seven pending bits plus one full code word
  localparam int ACCW = MAX_CODE_LEN + BYTE_W - 1;
  localparam int TOTW = $clog2(MAX_CODE_LEN + BYTE_W);
  localparam logic [TOTW-1:0] BYTE_CNT = TOTW'(BYTE_W);

  logic [ACCW-1:0]   acc_r, acc_nxt;
  logic [TOTW-1:0]   tot_r, tot_nxt;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  logic              idle;
  logic              can_emit;
  logic [ACCW-1:0]   enc_acc;
  logic [TOTW-1:0]   enc_tot;
  logic [TOTW-1:0]   rem;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;

  // fewer than eight bits held means the next command may start
  assign idle     = (tot_r < BYTE_CNT);
  assign can_emit = !out_vld_r || out_tready;
  assign enc_acc  = (ACCW'(q_cmd.code) << tot_r[2:0]) | acc_r;
  assign enc_tot  = tot_r + TOTW'(q_cmd.len);

  // packing control
  always_comb begin
    acc_nxt   = acc_r;
    tot_nxt   = tot_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_byte = acc_r[BYTE_W-1:0];
    emit_last = 1'b0;
    rem       = tot_r - BYTE_CNT;
    if (!idle) begin
      // drain remaining whole bytes of the current code
      if (can_emit) begin
        emit      = 1'b1;
        emit_last = (rem < BYTE_CNT);
        acc_nxt   = acc_r >> BYTE_W;
        tot_nxt   = rem;
      end
    end else if (q_vld) begin
      case (q_cmd.kind)
        CMD_ENCODE: begin
          rem = enc_tot - BYTE_CNT;
          if (enc_tot < BYTE_CNT) begin
            q_pop   = 1'b1;
            acc_nxt = enc_acc;
            tot_nxt = enc_tot;
          end else if (can_emit) begin
            q_pop     = 1'b1;
            emit      = 1'b1;
            emit_byte = enc_acc[BYTE_W-1:0];
            emit_last = (rem < BYTE_CNT);
            acc_nxt   = enc_acc >> BYTE_W;
            tot_nxt   = rem;
          end
        end
        CMD_FLUSH: begin
          if (tot_r == '0) begin
            q_pop = 1'b1;
          end else if (can_emit) begin
            q_pop     = 1'b1;
            emit      = 1'b1;
            emit_last = 1'b1;
            acc_nxt   = '0;
            tot_nxt   = '0;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      tot_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      tot_r <= tot_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/huffman_code_bit_packer_core.sv]
// top level of the huffman code bit packer: front end, queue, back end
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back and the assert header
//
//  channel | ports      | payload
//  --------+------------+----------------------------------------------------
//  input   | in_t*      | tuser mode; tdata symbol, code_word, code_length
//  result  | out_t*     | tdata out_byte; tlast last_of_run
//
// an item is accepted every cycle while the command queue has room; load
// items finish in the front end; flush and in-range encode items reach the
// back end through the lookup register and the command queue, and their bytes
// leave through the output register; the back end emits one byte per cycle
// while the result port is ready and takes no new command while it holds
// eight bits or more; reset clears the code table through per-entry valid bits
// a stalled result port fills the queue and then drops in_tready
`include "huffman_code_bit_packer_core_assert.svh"

module huffman_code_bit_packer_core #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
  input  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] mode
  input  logic [hcbp_pkg::MODE_W-1:0]    in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_byte
  output logic [hcbp_pkg::BYTE_W-1:0]    out_tdata,
  output logic                           out_tlast
);
  import hcbp_pkg::*;

  logic            q_push;
  cmd_t            q_push_cmd;
  logic            q_pop;
  logic            q_vld;
  cmd_t            q_head;
  logic [QC_W-1:0] q_level;

  // accept, classify and look up
  hcbp_front #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_level   (q_level),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // decoupling queue
  hcbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_cmd (q_head),
    .level    (q_level)
  );

  // bit packing and byte output
  hcbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // checks
  `HCBP_ASSERT_NEVER(a_queue_no_overflow, clk, rst_n, q_push && !q_pop && (q_level == QC_W'(Q_DEPTH)), "command queue overflow")
  `HCBP_ASSERT_IMPL(a_pop_needs_cmd, clk, rst_n, q_pop, q_vld, "back end popped an empty queue")
  `HCBP_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, q_vld, "pushed command missing from queue")

endmodule
